>>> rtl/pf_pkg.sv
// Shared types, constants and grid helpers for the Playfair digraph encryptor.
// Used by pf_ctrl, pf_datapath, playfair_digraph_encrypt and pf_checker.
`default_nettype none

package pf_pkg;

    // Grid geometry
    localparam int GRID_SIDE  = 5;
    localparam int GRID_SLOTS = 25;
    localparam int ALPHABET   = 26;

    // Letter indexes (A = 0)
    localparam logic [4:0] IDX_I    = 5'd8;
    localparam logic [4:0] IDX_J    = 5'd9;
    localparam logic [4:0] IDX_X    = 5'd23;
    localparam logic [4:0] IDX_LAST = 5'd25;

    localparam logic [6:0] ASCII_A = 7'd65;

    // Item modes
    typedef enum logic [2:0] {
        MODE_CLEAR = 3'd0,
        MODE_KEY   = 3'd1,
        MODE_SEAL  = 3'd2,
        MODE_TEXT  = 3'd3,
        MODE_END   = 3'd4
    } t_mode;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic clear_key;
        logic place_key;
        logic seal_start;
        logic seal_step;
        logic seal_finish;
        logic pend_load;
        logic pair_text;
        logic pair_msg_end;
        logic rd_pos_b;
        logic cap_p1;
        logic calc;
        logic rd_grid_b;
        logic cap_c1;
        logic cap_c2;
        logic emit_first;
        logic emit_second;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] mode;
        logic       is_letter;
        logic       letter_used;
        logic       grid_full;
        logic       key_ready;
        logic       pend_valid;
        logic       seal_last;
        logic       out_free;
    } t_dp_status;

    // Row of a grid slot (0..24) by compare chain
    function automatic logic [2:0] slot_row(input logic [4:0] slot);
        logic [2:0] row;
        row = 3'd0;
        for (int k = 1; k < GRID_SIDE; k++) begin
            if (slot >= 5'(k * GRID_SIDE)) row = 3'(k);
        end
        return row;
    endfunction

    // Column of a grid slot
    function automatic logic [2:0] slot_col(input logic [4:0] slot);
        logic [4:0] base;
        base = 5'(slot_row(slot) * GRID_SIDE);
        return 3'(slot - base);
    endfunction

    // Step one row or column with wraparound
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(GRID_SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    // Slot from row and column
    function automatic logic [4:0] slot_of(input logic [2:0] row, input logic [2:0] col);
        return 5'(5'(row * GRID_SIDE) + {2'b00, col});
    endfunction

endpackage

`default_nettype wire

>>> rtl/playfair_digraph_encrypt.sv
// Playfair digraph encryptor (5x5 grid, I and J merged); pf_ctrl, pf_datapath, pf_ram, pf_pkg.
// Clear, key byte and unpaired text items: loaded, then executed in S_EXEC; no new item meanwhile.
// Seal: one alphabet letter per cycle through the placement port of the RAMs.
// A pair: position RAM reads (S_POS_A/B), slot calc (S_CALC), grid RAM reads (S_GRID_A/B/C),
// then S_EMIT_1 and S_EMIT_2, which wait on output stall; serial RAM reads (one read port each).
// Synchronous active-low reset clears the key state; no clearing pass.
`default_nettype none

module playfair_digraph_encrypt (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_char_code,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [6:0] o_cipher_letter,
    output logic            o_pair_end
);
    import pf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cipher_letter (o_cipher_letter),
        .o_pair_end      (o_pair_end)
    );

endmodule

`default_nettype wire

>>> rtl/pf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/pf_ctrl.sv
// Sequencer for the Playfair encryptor: decodes each item and steps the datapath.
// Depends on pf_pkg.
`default_nettype none

module pf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire pf_pkg::t_dp_status i_status,
    output pf_pkg::t_dp_cmd         o_cmd
);
    import pf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SEAL,
        S_POS_A,
        S_POS_B,
        S_CALC,
        S_GRID_A,
        S_GRID_B,
        S_GRID_C,
        S_EMIT_1,
        S_EMIT_2
    } t_state;

    t_state  r_state, n_state;
    logic    r_stall, n_stall;
    t_dp_cmd cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_status.mode)
                    MODE_CLEAR: cmd.clear_key = 1'b1;
                    MODE_KEY: begin
                        cmd.place_key = !i_status.key_ready && i_status.is_letter &&
                                        !i_status.letter_used && !i_status.grid_full;
                    end
                    MODE_SEAL: begin
                        if (!i_status.key_ready) begin
                            cmd.seal_start = 1'b1;
                            n_state        = S_SEAL;
                        end
                    end
                    MODE_TEXT: begin
                        if (i_status.key_ready && i_status.is_letter) begin
                            if (!i_status.pend_valid) begin
                                cmd.pend_load = 1'b1;
                            end else begin
                                cmd.pair_text = 1'b1;
                                n_state       = S_POS_A;
                            end
                        end
                    end
                    MODE_END: begin
                        if (i_status.key_ready && i_status.pend_valid) begin
                            cmd.pair_msg_end = 1'b1;
                            n_state          = S_POS_A;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SEAL: begin
                cmd.seal_step = 1'b1;
                if (i_status.seal_last) begin
                    cmd.seal_finish = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_POS_A: n_state = S_POS_B;
            S_POS_B: begin
                cmd.rd_pos_b = 1'b1;
                cmd.cap_p1   = 1'b1;
                n_state      = S_CALC;
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                n_state  = S_GRID_A;
            end
            S_GRID_A: n_state = S_GRID_B;
            S_GRID_B: begin
                cmd.rd_grid_b = 1'b1;
                cmd.cap_c1    = 1'b1;
                n_state       = S_GRID_C;
            end
            S_GRID_C: begin
                cmd.cap_c2 = 1'b1;
                n_state    = S_EMIT_1;
            end
            S_EMIT_1: begin
                if (i_status.out_free) begin
                    cmd.emit_first = 1'b1;
                    n_state        = S_EMIT_2;
                end
            end
            S_EMIT_2: begin
                if (i_status.out_free) begin
                    cmd.emit_second = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;
    assign o_cmd   = cmd;

endmodule

`default_nettype wire

>>> rtl/pf_datapath.sv
// Datapath of the Playfair encryptor: key state, grid and position RAMs,
// pair geometry and the output register. Depends on pf_pkg and pf_ram.
`default_nettype none

module pf_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [2:0]       i_mode,
    input  wire logic [7:0]       i_char_code,
    input  wire pf_pkg::t_dp_cmd  i_cmd,
    output pf_pkg::t_dp_status    o_status,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [6:0]       o_cipher_letter,
    output logic                  o_pair_end
);
    import pf_pkg::*;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [ALPHABET-1:0] USED_RESET = ALPHABET'(1) << IDX_J;

    // Control registers
    logic [ALPHABET-1:0] r_used;
    logic [4:0]          r_fill;
    logic [4:0]          r_seal_idx;
    logic                r_key_ready;
    logic                r_pend_valid;
    logic                r_out_valid;

    // Payload registers
    logic [2:0] r_mode;
    logic [4:0] r_letter;
    logic       r_is_letter;
    logic [4:0] r_pend_letter;
    logic [4:0] r_a, r_b;
    logic [4:0] r_p1;
    logic [4:0] r_s1, r_s2;
    logic [4:0] r_c1, r_c2;
    logic [6:0] r_out_letter;
    logic       r_out_pair_end;

    logic [7:0] up_code;
    logic       item_is_letter;
    logic [4:0] item_letter;
    logic [4:0] txt_letter;
    logic       grid_full;
    logic       place_en;
    logic [4:0] place_letter;
    logic [4:0] pos_raddr, grid_raddr;
    logic [4:0] pos_rdata, grid_rdata;
    logic [2:0] row1, col1, row2, col2;
    logic [4:0] n_s1, n_s2;

    // Upper-case the incoming byte and map it to a letter index
    always_comb begin
        up_code = i_char_code;
        if (i_char_code >= CHAR_LOWER_A && i_char_code <= CHAR_LOWER_Z) begin
            up_code = i_char_code - CASE_OFFSET;
        end
        item_is_letter = (up_code >= CHAR_UPPER_A) && (up_code <= CHAR_UPPER_Z);
        item_letter    = item_is_letter ? 5'(up_code - CHAR_UPPER_A) : 5'd0;
    end

    assign txt_letter = (r_letter == IDX_J) ? IDX_I : r_letter;
    assign grid_full  = (r_fill == 5'(GRID_SLOTS));

    // Key placement: one letter per cycle, from a key byte or the seal sweep
    assign place_letter = i_cmd.seal_step ? r_seal_idx : r_letter;
    assign place_en     = i_cmd.place_key ||
                          (i_cmd.seal_step && !r_used[r_seal_idx] && !grid_full);

    // Read address selection
    assign pos_raddr  = i_cmd.rd_pos_b  ? r_b  : r_a;
    assign grid_raddr = i_cmd.rd_grid_b ? r_s2 : r_s1;

    pf_ram #(
        .WIDTH (5),
        .DEPTH (GRID_SLOTS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (r_fill),
        .i_wdata (place_letter),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    pf_ram #(
        .WIDTH (5),
        .DEPTH (ALPHABET)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (place_letter),
        .i_wdata (r_fill),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // Pair geometry: first slot registered, second straight from the RAM
    always_comb begin
        row1 = slot_row(r_p1);
        col1 = slot_col(r_p1);
        row2 = slot_row(pos_rdata);
        col2 = slot_col(pos_rdata);
        if (row1 == row2) begin
            n_s1 = slot_of(row1, wrap_inc(col1));
            n_s2 = slot_of(row2, wrap_inc(col2));
        end else if (col1 == col2) begin
            n_s1 = slot_of(wrap_inc(row1), col1);
            n_s2 = slot_of(wrap_inc(row2), col2);
        end else begin
            n_s1 = slot_of(row1, col2);
            n_s2 = slot_of(row2, col1);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= USED_RESET;
            r_fill       <= 5'd0;
            r_seal_idx   <= 5'd0;
            r_key_ready  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear_key) begin
                r_used       <= USED_RESET;
                r_fill       <= 5'd0;
                r_key_ready  <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (place_en) begin
                r_used[place_letter] <= 1'b1;
                r_fill               <= r_fill + 5'd1;
            end
            if (i_cmd.seal_start) begin
                r_seal_idx <= 5'd0;
            end else if (i_cmd.seal_step) begin
                r_seal_idx <= r_seal_idx + 5'd1;
            end
            if (i_cmd.seal_finish) begin
                r_key_ready <= 1'b1;
            end
            if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.pair_text && (txt_letter != r_pend_letter)) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.pair_msg_end) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit_first || i_cmd.emit_second) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode      <= i_mode;
            r_letter    <= item_letter;
            r_is_letter <= item_is_letter;
        end
        if (i_cmd.clear_key) begin
            r_pend_letter <= 5'd0;
        end
        if (i_cmd.pend_load) begin
            r_pend_letter <= txt_letter;
        end
        // doubled letter: pair with filler, pending letter stays as is
        if (i_cmd.pair_text) begin
            r_a <= r_pend_letter;
            r_b <= (txt_letter == r_pend_letter) ? IDX_X : txt_letter;
        end
        if (i_cmd.pair_msg_end) begin
            r_a <= r_pend_letter;
            r_b <= IDX_X;
        end
        if (i_cmd.cap_p1) begin
            r_p1 <= pos_rdata;
        end
        if (i_cmd.calc) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
        if (i_cmd.cap_c1) begin
            r_c1 <= grid_rdata;
        end
        if (i_cmd.cap_c2) begin
            r_c2 <= grid_rdata;
        end
        if (i_cmd.emit_first) begin
            r_out_letter   <= ASCII_A + {2'b00, r_c1};
            r_out_pair_end <= 1'b0;
        end else if (i_cmd.emit_second) begin
            r_out_letter   <= ASCII_A + {2'b00, r_c2};
            r_out_pair_end <= 1'b1;
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.mode        = r_mode;
        o_status.is_letter   = r_is_letter;
        o_status.letter_used = r_used[r_letter];
        o_status.grid_full   = grid_full;
        o_status.key_ready   = r_key_ready;
        o_status.pend_valid  = r_pend_valid;
        o_status.seal_last   = (r_seal_idx == IDX_LAST);
        o_status.out_free    = !r_out_valid || !i_stall;
    end

    assign o_valid         = r_out_valid;
    assign o_cipher_letter = r_out_letter;
    assign o_pair_end      = r_out_pair_end;

endmodule

`default_nettype wire

>>> rtl/pf_checker.sv
// Port-level checks for playfair_digraph_encrypt, bound to the top level.
// Depends on pf_pkg.
`default_nettype none

module pf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [2:0] i_mode,
    input wire logic [7:0] i_char_code,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_cipher_letter,
    input wire logic       o_pair_end
);
    import pf_pkg::*;

    logic r_second_due;

    // Tracks whether the next output item must close a digraph
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_due <= 1'b0;
        end else if (o_valid && !i_stall) begin
            r_second_due <= !o_pair_end;
        end
    end

    // Held output stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_letter) && $stable(o_pair_end))
        else $error("output item changed while stalled");

    // Letters alternate first/second within a digraph
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pair_end == r_second_due))
        else $error("digraph letters out of order");

    // Only uppercase letters leave the block
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cipher_letter >= ASCII_A) && (o_cipher_letter <= 7'd90))
        else $error("cipher letter out of range");

    // A new digraph appears while its second letter is still being made
    a_first_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && !o_pair_end |-> o_stall)
        else $error("first letter shown with input side open");

    // Clear key frees the input again once its execute state is done
    a_clear_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == MODE_CLEAR) |=> ##1 !o_stall)
        else $error("clear key did not finish in two cycles");

endmodule

bind playfair_digraph_encrypt pf_checker u_pf_checker (.*);

`default_nettype wire
